FILE: rtl/core/w2s_pkg.sv
package w2s_pkg;

	// Fixed field and datapath widths
	localparam int WORD_W = 32;
	localparam int CLIP_W = 40;
	localparam int NUM_W  = 40;
	localparam int QUO_W  = 41;
	localparam int DIM_W  = 14;
	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int PROD_W = 57;

	// Divider latency: input register, one stage per quotient bit, clamp register
	localparam int DIV_LAT = QUO_W + 2;

	localparam logic signed [17:0] BEHIND_SCALE = 18'sd100000;

	// Register indexes (byte address / 8)
	typedef enum logic [2:0] {
		REG_ROW0_01 = 3'd0,
		REG_ROW0_23 = 3'd1,
		REG_ROW1_01 = 3'd2,
		REG_ROW1_23 = 3'd3,
		REG_ROW3_01 = 3'd4,
		REG_ROW3_23 = 3'd5,
		REG_WIDTH   = 3'd6,
		REG_HEIGHT  = 3'd7
	} reg_idx_t;

	typedef logic [5:0][DATA_W-1:0] mat_regs_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] point_x;
		logic signed [WORD_W-1:0] point_y;
		logic signed [WORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic                     on_screen;
		logic signed [WORD_W-1:0] screen_x;
		logic signed [WORD_W-1:0] screen_y;
	} result_t;

	typedef struct packed {
		logic signed [CLIP_W-1:0] cx;
		logic signed [CLIP_W-1:0] cy;
		logic signed [CLIP_W-1:0] cw;
	} clip_t;

	// Side data that travels alongside the divider
	typedef struct packed {
		logic                     near;
		logic                     negx;
		logic                     negy;
		logic signed [PROD_W-1:0] bx;
		logic signed [PROD_W-1:0] by;
	} side_t;

endpackage

FILE: rtl/core/w2s_dot.sv
module w2s_dot import w2s_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  point_t    pt,
	input  mat_regs_t mat,
	output logic      out_valid,
	output clip_t     clip
);

	localparam int SUM_W = 2 * WORD_W + 2;
	localparam logic signed [SUM_W-1:0] CLIP_MAX = (SUM_W'(1) <<< (CLIP_W - 1)) - 1;
	localparam logic signed [SUM_W-1:0] CLIP_MIN = -(SUM_W'(1) <<< (CLIP_W - 1));

	logic signed [WORD_W-1:0]   coord [0:2];
	logic signed [WORD_W-1:0]   word  [0:2][0:3];
	logic signed [2*WORD_W-1:0] prod  [0:2][0:2];
	logic signed [2*WORD_W-1:0] prod_s1 [0:2][0:2];
	logic signed [WORD_W-1:0]   col3_s1 [0:2];
	logic signed [SUM_W-1:0]    sum   [0:2];
	logic                       valid_s1, valid_s2;
	clip_t                      clip_s2;

	assign coord[0] = pt.point_x;
	assign coord[1] = pt.point_y;
	assign coord[2] = pt.point_z;

	// Matrix words: rows 0, 1 and 3 live in register pairs 0/1, 2/3, 4/5
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			word[r][0] = mat[2*r][WORD_W-1:0];
			word[r][1] = mat[2*r][DATA_W-1:WORD_W];
			word[r][2] = mat[2*r+1][WORD_W-1:0];
			word[r][3] = mat[2*r+1][DATA_W-1:WORD_W];
		end
	end

	// Stage 1: nine exact products, floored to the coordinate format
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod[r][c] = (2*WORD_W)'(word[r][c]) * (2*WORD_W)'(coord[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= prod[r][c] >>> FRACTION_BITS;
			end
			col3_s1[r] <= word[r][3];
		end
	end

	// Stage 2: row sums, clamped to the clip width
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum[r] = SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1])
			       + SUM_W'(prod_s1[r][2]) + SUM_W'(col3_s1[r]);
			if (sum[r] > CLIP_MAX) begin
				sum[r] = CLIP_MAX;
			end else if (sum[r] < CLIP_MIN) begin
				sum[r] = CLIP_MIN;
			end
		end
	end

	always_ff @(posedge clk) begin
		clip_s2.cx <= sum[0][CLIP_W-1:0];
		clip_s2.cy <= sum[1][CLIP_W-1:0];
		clip_s2.cw <= sum[2][CLIP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign clip      = clip_s2;

endmodule

FILE: rtl/core/w2s_div.sv
module w2s_div import w2s_pkg::*; #(
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output logic [QUO_W-1:0] quo
);

	localparam int DW = NUM_W + FRACTION_BITS;
	localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(1) << (QUO_W - 1);

	logic [DW-1:0]    dvd;
	logic [QUO_W-1:0] head;
	logic             head_ovf;

	logic [NUM_W-1:0] rem_s  [0:QUO_W];
	logic [QUO_W-1:0] low_s  [0:QUO_W];
	logic [QUO_W-1:0] quo_s  [0:QUO_W];
	logic [NUM_W-1:0] den_s  [0:QUO_W];
	logic             ovf_s  [0:QUO_W];
	logic [QUO_W-1:0] quo_q;

	// Dividend is the magnitude scaled up by the fraction bits
	assign dvd      = {num, {FRACTION_BITS{1'b0}}};
	assign head     = QUO_W'(dvd[DW-1:QUO_W]);
	assign head_ovf = head >= {1'b0, den};

	// Input stage: bits above the quotient range seed the remainder, or flag overflow when they reach the divisor
	always_ff @(posedge clk) begin
		rem_s[0] <= head_ovf ? '0 : head[NUM_W-1:0];
		low_s[0] <= dvd[QUO_W-1:0];
		quo_s[0] <= '0;
		den_s[0] <= den;
		ovf_s[0] <= head_ovf;
	end

	// One restoring step per stage, most significant quotient bit first
	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [QUO_W-1:0] trial;
		logic [QUO_W-1:0] diff;
		logic             ge;

		assign trial = {rem_s[k-1], low_s[k-1][QUO_W-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
			low_s[k] <= low_s[k-1] << 1;
			quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge};
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	// Clamp the magnitude to the normalized-coordinate limit
	always_ff @(posedge clk) begin
		if (ovf_s[QUO_W] || quo_s[QUO_W] > QUO_MAX) begin
			quo_q <= QUO_MAX;
		end else begin
			quo_q <= quo_s[QUO_W];
		end
	end

	assign quo = quo_q;

endmodule

FILE: rtl/core/world_to_screen_projection_core.sv
// Projects one world point per clock through matrix rows 0, 1 and 3 into pixel
// coordinates. A point is taken whenever start is high (busy is always low) and
// its result appears on result with done high after the two dot-product stages,
// the perspective divider and the two viewport stages; the result is shown for
// one cycle only and the receiver must take it then. The perspective divider is
// a restoring divider with one register stage per quotient bit (41), plus its
// input and clamp registers. Matrix and screen registers are written over the
// APB port; the user must do so only while no points are in flight, as the
// block itself does not enforce it.
module world_to_screen_projection_core import w2s_pkg::*; #(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  point_t            point,
	output logic              done,
	output result_t           result
);

	localparam int WIDE_W = 64;
	localparam int NDC_W  = QUO_W + 1;
	localparam logic signed [CLIP_W-1:0] NEAR_CODE =
		CLIP_W'((64'sd1 <<< FRACTION_BITS) / 1000);
	localparam logic signed [WIDE_W-1:0] OUT_MAX = (WIDE_W'(1) <<< (COORD_WIDTH - 1)) - 1;
	localparam logic signed [WIDE_W-1:0] OUT_MIN = -(WIDE_W'(1) <<< (COORD_WIDTH - 1));
	localparam logic signed [WIDE_W-1:0] HALF    = WIDE_W'(1) <<< (FRACTION_BITS - 1);

	function automatic logic [WORD_W-1:0] sat_out(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] c;
		c = v;
		if (c > OUT_MAX) begin
			c = OUT_MAX;
		end else if (c < OUT_MIN) begin
			c = OUT_MIN;
		end
		return c[WORD_W-1:0];
	endfunction

	mat_regs_t         mat_q;
	logic [DIM_W-1:0]  width_q, height_q;
	reg_idx_t          idx;
	logic              cfg_wr;

	logic              dot_valid;
	clip_t             clip;
	logic [NUM_W-1:0]  magx, magy;
	logic [QUO_W-1:0]  qx, qy;

	side_t             side_s3 [0:DIV_LAT-1];
	logic              valid_s3 [0:DIV_LAT-1];

	side_t                    side_s4;
	logic                     valid_s4;
	logic signed [PROD_W-1:0] mx_s4, my_s4;
	logic signed [NDC_W-1:0]  nx, ny;

	result_t                  result_s5;
	logic                     valid_s5;
	logic signed [WIDE_W-1:0] px, py;

	// Configuration port
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q    <= '0;
			width_q  <= DIM_W'(1920);
			height_q <= DIM_W'(1080);
		end else if (cfg_wr) begin
			unique case (idx)
				REG_ROW0_01: mat_q[0] <= pwdata;
				REG_ROW0_23: mat_q[1] <= pwdata;
				REG_ROW1_01: mat_q[2] <= pwdata;
				REG_ROW1_23: mat_q[3] <= pwdata;
				REG_ROW3_01: mat_q[4] <= pwdata;
				REG_ROW3_23: mat_q[5] <= pwdata;
				REG_WIDTH:   width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT:  height_q <= pwdata[DIM_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ROW0_01: prdata = mat_q[0];
			REG_ROW0_23: prdata = mat_q[1];
			REG_ROW1_01: prdata = mat_q[2];
			REG_ROW1_23: prdata = mat_q[3];
			REG_ROW3_01: prdata = mat_q[4];
			REG_ROW3_23: prdata = mat_q[5];
			REG_WIDTH:   prdata = DATA_W'(width_q);
			REG_HEIGHT:  prdata = DATA_W'(height_q);
		endcase
	end

	// Clip-space dot products
	w2s_dot #(.FRACTION_BITS(FRACTION_BITS)) u_dot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pt        (point),
		.mat       (mat_q),
		.out_valid (dot_valid),
		.clip      (clip)
	);

	// Perspective divide on magnitudes; w is positive whenever the result is used
	assign magx = clip.cx[CLIP_W-1] ? NUM_W'(-clip.cx) : NUM_W'(clip.cx);
	assign magy = clip.cy[CLIP_W-1] ? NUM_W'(-clip.cy) : NUM_W'(clip.cy);

	w2s_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_x (
		.clk (clk),
		.num (magx),
		.den (clip.cw),
		.quo (qx)
	);

	w2s_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_y (
		.clk (clk),
		.num (magy),
		.den (clip.cw),
		.quo (qy)
	);

	// Stage 3: near test, signs and behind-viewer scaling, then delayed with the divider
	always_ff @(posedge clk) begin
		side_s3[0].near <= clip.cw < NEAR_CODE;
		side_s3[0].negx <= clip.cx[CLIP_W-1];
		side_s3[0].negy <= clip.cy[CLIP_W-1];
		side_s3[0].bx   <= PROD_W'(clip.cx) * PROD_W'(BEHIND_SCALE);
		side_s3[0].by   <= PROD_W'(clip.cy) * PROD_W'(BEHIND_SCALE);
		for (int i = 1; i < DIV_LAT; i++) begin
			side_s3[i] <= side_s3[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				valid_s3[i] <= 1'b0;
			end
		end else begin
			valid_s3[0] <= dot_valid;
			for (int i = 1; i < DIV_LAT; i++) begin
				valid_s3[i] <= valid_s3[i-1];
			end
		end
	end

	// Stage 4: signed NDC scaled by the screen size
	assign nx = side_s3[DIV_LAT-1].negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign ny = side_s3[DIV_LAT-1].negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

	always_ff @(posedge clk) begin
		side_s4 <= side_s3[DIV_LAT-1];
		mx_s4   <= PROD_W'(nx) * PROD_W'($signed({1'b0, width_q}));
		my_s4   <= PROD_W'(ny) * PROD_W'($signed({1'b0, height_q}));
	end

	// Stage 5: viewport offset, saturation and result select (all signed)
	assign px = ($signed(WIDE_W'(width_q >> 1)) <<< FRACTION_BITS)
	          + (WIDE_W'(mx_s4) >>> 1) + HALF;
	assign py = ($signed(WIDE_W'(height_q >> 1)) <<< FRACTION_BITS)
	          - ((WIDE_W'(my_s4) >>> 1) + HALF);

	always_ff @(posedge clk) begin
		if (side_s4.near) begin
			result_s5.on_screen <= 1'b0;
			result_s5.screen_x  <= sat_out(WIDE_W'(side_s4.bx));
			result_s5.screen_y  <= sat_out(WIDE_W'(side_s4.by));
		end else begin
			result_s5.on_screen <= 1'b1;
			result_s5.screen_x  <= sat_out(px);
			result_s5.screen_y  <= sat_out(py);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3[DIV_LAT-1];
			valid_s5 <= valid_s4;
		end
	end

	assign done   = valid_s5;
	assign result = result_s5;

endmodule

FILE: tb/world_to_screen_projection_core_test.sv
`timescale 1ns / 100ps

module world_to_screen_projection_core_test;
	import w2s_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = DIV_LAT + 4;
	localparam longint CLIP_MAX = (64'sd1 <<< 39) - 1;
	localparam longint CLIP_MIN = -(64'sd1 <<< 39);
	localparam longint NDC_MAX = 64'sd1 <<< 40;
	localparam longint OUT_MAX = 64'sd2147483647;
	localparam longint OUT_MIN = -64'sd2147483648;
	localparam longint NEAR_CODE = 65;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	point_t point = '0;
	logic done;
	result_t result;

	world_to_screen_projection_core DUT (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .point(point), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	// Shadow copy of the configuration
	logic [DATA_W-1:0] mat_shadow [6];
	logic [DIM_W-1:0] width_shadow = 14'd1920;
	logic [DIM_W-1:0] height_shadow = 14'd1080;

	point_t points_pending[$];
	result_t projections_due[$];
	int errors = 0;
	int cycles = 0;
	int points_sent = 0;
	int results_seen = 0;
	int behind_seen = 0;
	int gap_left = 0;
	bit idle_on = 1'b1;
	bit stim_done = 1'b0;

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint mat_word(int row, int col);
		logic [63:0] r;
		r = mat_shadow[row * 2 + col / 2];
		return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
	endfunction

	// Floored products (>>> on signed 64-bit is a floor), column 3 added as is
	function automatic longint clip_dot(int row, longint x, longint y, longint z);
		longint s;
		s = ((mat_word(row, 0) * x) >>> FRAC) + ((mat_word(row, 1) * y) >>> FRAC)
			+ ((mat_word(row, 2) * z) >>> FRAC) + mat_word(row, 3);
		return clamp(s, CLIP_MIN, CLIP_MAX);
	endfunction

	function automatic result_t project_point(point_t p);
		result_t r;
		longint cx, cy, cw, nx, ny, w, h, sx, sy;
		cx = clip_dot(0, p.point_x, p.point_y, p.point_z);
		cy = clip_dot(1, p.point_x, p.point_y, p.point_z);
		cw = clip_dot(2, p.point_x, p.point_y, p.point_z);
		if (cw < NEAR_CODE) begin
			r.on_screen = 1'b0;
			sx = clamp(cx * 100000, OUT_MIN, OUT_MAX);
			sy = clamp(cy * 100000, OUT_MIN, OUT_MAX);
		end else begin
			w = longint'(width_shadow);
			h = longint'(height_shadow);
			nx = clamp((cx <<< FRAC) / cw, -NDC_MAX, NDC_MAX);
			ny = clamp((cy <<< FRAC) / cw, -NDC_MAX, NDC_MAX);
			r.on_screen = 1'b1;
			sx = clamp(((w >>> 1) <<< FRAC) + ((nx * w) >>> 1) + (64'sd1 <<< (FRAC - 1)),
				OUT_MIN, OUT_MAX);
			sy = clamp(((h >>> 1) <<< FRAC) - (((ny * h) >>> 1) + (64'sd1 <<< (FRAC - 1))),
				OUT_MIN, OUT_MAX);
		end
		r.screen_x = sx[31:0];
		r.screen_y = sy[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
		errors++;
	endtask

	// Driver: one transfer per accepted start, random gap bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				projections_due.push_back(project_point(point));
				points_sent++;
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 8);
				start <= 1'b0;
			end else if (points_pending.size() > 0 && !(start && busy)) begin
				point <= points_pending.pop_front();
				start <= 1'b1;
			end else if (!(start && busy)) begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			results_seen++;
			if (projections_due.size() == 0) begin
				$display("MISMATCH unexpected result %0d", results_seen);
				errors++;
			end else begin
				want = projections_due.pop_front();
				if (!result.on_screen) behind_seen++;
				if (result.on_screen !== want.on_screen)
					report_mismatch("on_screen", result.on_screen, want.on_screen);
				if (result.screen_x !== want.screen_x)
					report_mismatch("screen_x", result.screen_x, want.screen_x);
				if (result.screen_y !== want.screen_y)
					report_mismatch("screen_y", result.screen_y, want.screen_y);
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 3;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < REG_WIDTH) mat_shadow[idx] = value;
		else if (idx == REG_WIDTH) width_shadow = value[DIM_W-1:0];
		else height_shadow = value[DIM_W-1:0];
	endtask

	task automatic drain;
		while (points_pending.size() > 0 || start || projections_due.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 20 << FRAC)) - (10 << FRAC));
			2: return 32'($signed($urandom_range(0, 1 << FRAC)) - (1 << (FRAC - 1)));
			default: return 32'($urandom_range(0, 127));
		endcase
	endfunction

	function automatic point_t rand_point(int mode);
		point_t p;
		p.point_x = rand_word(mode);
		p.point_y = rand_word(mode);
		p.point_z = rand_word(mode);
		return p;
	endfunction

	// Perspective-like matrix unless mode is 0 (fully random words): w comes mostly from z, sometimes near zero
	task automatic load_matrix(int mode);
		logic [31:0] m [12];
		for (int i = 0; i < 12; i++) m[i] = rand_word(mode == 0 ? 0 : 2);
		if (mode != 0) begin
			m[0] = 32'($urandom_range(1 << (FRAC - 1), 2 << FRAC));
			m[5] = 32'($urandom_range(1 << (FRAC - 1), 2 << FRAC));
			m[8] = rand_word(2) >>> 4;
			m[9] = rand_word(2) >>> 4;
			m[10] = $urandom_range(0, 1) ? 32'(1 << FRAC) : -32'(1 << FRAC);
			m[11] = 32'($signed($urandom_range(0, 400)) - 200);
		end
		for (int r = 0; r < 3; r++) begin
			write_reg(reg_idx_t'(2 * r), {m[4 * r + 1], m[4 * r]});
			write_reg(reg_idx_t'(2 * r + 1), {m[4 * r + 3], m[4 * r + 2]});
		end
	endtask

	initial begin
		logic [DIM_W-1:0] dims [5] = '{14'd1, 14'd8192, 14'd0, 14'd1920, 14'd640};
		point_t p;
		for (int i = 0; i < 6; i++) mat_shadow[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity-like matrix, w = z: near threshold and extremes
		write_reg(REG_ROW0_01, {32'h0, 32'h0001_0000});
		write_reg(REG_ROW0_23, {32'h0, 32'h0});
		write_reg(REG_ROW1_01, {32'h0001_0000, 32'h0});
		write_reg(REG_ROW1_23, {32'h0, 32'h0});
		write_reg(REG_ROW3_01, {32'h0, 32'h0});
		write_reg(REG_ROW3_23, {32'h0, 32'h0001_0000});
		points_pending.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'd65});
		points_pending.push_back('{32'h0001_0000, 32'hFFFF_0000, 32'd64});
		points_pending.push_back('{32'h0001_0000, 32'h0002_0000, 32'd66});
		points_pending.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000});
		points_pending.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
		points_pending.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		points_pending.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		points_pending.push_back('{32'h0, 32'h0, 32'h0});
		points_pending.push_back('{32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000});
		drain();
		write_reg(REG_WIDTH, 14'd0);
		write_reg(REG_HEIGHT, 14'd8192);
		points_pending.push_back('{32'h0000_8000, 32'h0000_8000, 32'h0001_0000});
		points_pending.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'd65});
		drain();
		// Largest matrix words
		write_reg(REG_ROW0_01, {32'h8000_0000, 32'h7FFF_FFFF});
		write_reg(REG_ROW1_23, {32'h7FFF_FFFF, 32'h8000_0000});
		write_reg(REG_ROW3_23, {32'hFFFF_FFFF, 32'h7FFF_FFFF});
		points_pending.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		points_pending.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		points_pending.push_back('{32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
		drain();

		// Random phases with varying matrices and viewports
		for (int ph = 0; ph < 12; ph++) begin
			load_matrix(ph % 4 == 3 ? 0 : 1);
			write_reg(REG_WIDTH, ph < 5 ? dims[ph] : 14'($urandom_range(0, 8192)));
			write_reg(REG_HEIGHT, ph < 5 ? dims[4 - ph] : 14'($urandom_range(0, 8192)));
			idle_on = (ph < 10);
			for (int i = 0; i < 150; i++) begin
				p = rand_point($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 3));
				if ($urandom_range(0, 3) != 0 && ph % 4 != 3)
					p.point_z = $urandom_range(0, 1) ? 32'($urandom_range(0, 200))
						: 32'($urandom_range(1 << FRAC, 20 << FRAC));
				points_pending.push_back(p);
			end
			drain();
		end
		stim_done = 1'b1;
	end

	// End of run and timeout
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end else if (stim_done && projections_due.size() == 0
				&& points_pending.size() == 0 && !start) begin
			repeat (LATENCY + 4) @(posedge clk);
			$display("Sent %0d points, checked %0d results over 15 matrix/viewport settings",
				points_sent, results_seen);
			$display("%0d of them behind the viewer", behind_seen);
			if (errors == 0 && projections_due.size() == 0)
				$display("Verification passed");
			else
				$display("Verification failed");
			$finish;
		end
	end

endmodule

FILE: files.f
rtl/core/w2s_pkg.sv
rtl/core/w2s_dot.sv
rtl/core/w2s_div.sv
rtl/core/world_to_screen_projection_core.sv
tb/world_to_screen_projection_core_test.sv
